// File: sv/dofifo_pkg.sv
// Package for the drop-oldest frame FIFO: sizes, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package dofifo_pkg;

    localparam int RING_DEPTH     = 16;
    localparam int SLOT_BYTES_MAX = 1024;

    localparam int BYTE_W = 8;
    localparam int SLOT_W = 11;
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int OFF_W  = $clog2(SLOT_BYTES_MAX);
    localparam int ADDR_W = $clog2(RING_DEPTH * SLOT_BYTES_MAX);

    typedef enum logic
    {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } ctrl_state_t;

    typedef struct packed
    {
        logic put;
        logic get;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic out_busy;
    } dp_stat_t;

    function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] idx);
        ring_next = (idx == RING_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// File: sv/dofifo_ctrl.sv
// Controller of the drop-oldest frame FIFO: input handshake and the
// two-state sequence of a get. Depends on dofifo_pkg.
module dofifo_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  dofifo_pkg::dp_stat_t stat,
    output dofifo_pkg::dp_cmd_t  cmd
);
    import dofifo_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        is_get;

    assign is_get = (operation == OP_GET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && is_get && !stat.out_busy)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // a get needs the output register free (or emptied this cycle)
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.put      = 1'b0;
        cmd.get      = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !is_get || !stat.out_busy;
                cmd.put  = in_valid && !is_get;
                cmd.get  = in_valid && is_get && !stat.out_busy;
            end
            S_READ:
            begin
                cmd.load_out = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/dofifo_dp.sv
// Datapath of the drop-oldest frame FIFO: ring pointers, frame store memory,
// length table, slot size register and output register. Depends on dofifo_pkg.
module dofifo_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dofifo_pkg::dp_cmd_t             cmd,
    output dofifo_pkg::dp_stat_t            stat,
    input  logic [dofifo_pkg::BYTE_W-1:0]   byte_in,
    input  logic                            frame_end,
    input  logic                            cfg_we,
    input  logic [dofifo_pkg::SLOT_W-1:0]   cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dofifo_pkg::BYTE_W-1:0]   byte_out,
    output logic                            status,
    output logic                            last
);
    import dofifo_pkg::*;

    logic [BYTE_W-1:0] store_mem [0:RING_DEPTH*SLOT_BYTES_MAX-1];
    logic [SLOT_W-1:0] len_mem   [0:RING_DEPTH-1];

    logic [SLOT_W-1:0] slot_reg;
    logic [RING_W-1:0] head_reg, head_next;
    logic [RING_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] wo_reg, wo_next;
    logic [SLOT_W-1:0] ro_reg, ro_next;
    logic              sil_reg, sil_next;
    logic              out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0] rd_reg;
    logic              pend_use_reg, pend_status_reg, pend_last_reg;
    logic [BYTE_W-1:0] byte_out_reg;
    logic              status_reg, last_reg;

    logic [SLOT_W-1:0] slot_eff;
    logic              drop;
    logic [CNT_W-1:0]  count_d;
    logic              store_en;
    logic [SLOT_W-1:0] wo_inc;
    logic              len_we;
    logic [SLOT_W-1:0] len_wdata;
    logic [ADDR_W-1:0] waddr, raddr;
    logic              start_sil, sil_d;
    logic [SLOT_W-1:0] ro_g;
    logic              is_last;
    logic              use_mem;

    assign slot_eff = (slot_reg == '0) ? SLOT_W'(1)
                    : (slot_reg > SLOT_W'(SLOT_BYTES_MAX)) ? SLOT_W'(SLOT_BYTES_MAX)
                    : slot_reg;

    // put path
    assign drop     = (wo_reg == '0) && (count_reg == CNT_W'(RING_DEPTH));
    assign count_d  = drop ? CNT_W'(RING_DEPTH - 1) : count_reg;
    assign store_en = cmd.put && (wo_reg < slot_eff);
    assign wo_inc   = (wo_reg < slot_eff) ? wo_reg + 1'b1 : wo_reg;
    assign len_we   = cmd.put && frame_end;
    assign len_wdata = (wo_inc < slot_eff) ? wo_inc : slot_eff;
    assign waddr    = ADDR_W'(tail_reg) * ADDR_W'(SLOT_BYTES_MAX) + ADDR_W'(wo_reg[OFF_W-1:0]);

    // get path
    assign start_sil = !sil_reg && (count_reg == '0);
    assign sil_d     = sil_reg || start_sil;
    assign ro_g      = start_sil ? '0 : ro_reg;
    assign is_last   = ({1'b0, ro_g} + 1'b1) >= {1'b0, slot_eff};
    assign use_mem   = !sil_d && (ro_g < len_mem[head_reg])
                    && (ro_g < SLOT_W'(SLOT_BYTES_MAX));
    assign raddr     = ADDR_W'(head_reg) * ADDR_W'(SLOT_BYTES_MAX) + ADDR_W'(ro_g[OFF_W-1:0]);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wo_next    = wo_reg;
        ro_next    = ro_reg;
        sil_next   = sil_reg;
        if (cmd.put)
        begin
            if (drop)
            begin
                head_next = ring_next(head_reg);
                if (!sil_reg)
                begin
                    ro_next = '0;
                end
            end
            count_next = count_d;
            wo_next    = wo_inc;
            if (frame_end)
            begin
                tail_next = ring_next(tail_reg);
                if (count_d < CNT_W'(RING_DEPTH))
                begin
                    count_next = count_d + 1'b1;
                end
                wo_next = '0;
            end
        end
        else if (cmd.get)
        begin
            if (sil_d)
            begin
                sil_next = !is_last;
                ro_next  = is_last ? '0 : ro_g + 1'b1;
            end
            else if (is_last)
            begin
                head_next  = ring_next(head_reg);
                count_next = count_reg - 1'b1;
                ro_next    = '0;
            end
            else
            begin
                ro_next = ro_g + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_W'(SLOT_BYTES_MAX);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            wo_reg        <= '0;
            ro_reg        <= '0;
            sil_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_reg <= cfg_data;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            wo_reg        <= wo_next;
            ro_reg        <= ro_next;
            sil_reg       <= sil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[waddr] <= byte_in;
        end
        if (cmd.get)
        begin
            rd_reg <= store_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[tail_reg] <= len_wdata;
        end
        if (cmd.get)
        begin
            pend_use_reg    <= use_mem;
            pend_status_reg <= sil_d;
            pend_last_reg   <= is_last;
        end
        if (cmd.load_out)
        begin
            byte_out_reg <= pend_use_reg ? rd_reg : '0;
            status_reg   <= pend_status_reg;
            last_reg     <= pend_last_reg;
        end
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign byte_out      = byte_out_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

// File: sv/drop_oldest_frame_fifo_unit.sv
// Top level of the drop-oldest frame FIFO.
// Depends on dofifo_pkg, dofifo_ctrl and dofifo_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per byte: operation 0
//   writes byte_in into the open frame, frame_end on its last byte commits
//   it; operation 1 asks for the next output byte.
//   Output channel (out_valid/out_ready) returns one item per get: byte_out,
//   status (1 = underrun silence, byte is zero) and last (final slot byte).
//   Config channel (cfg_valid/cfg_ready) writes slot_bytes; cfg_ready is
//   always high. Write it only while no item is in flight.
// Timing:
//   Puts stream at one item per cycle except while a get is in S_READ.
//   A get passes through S_READ: the frame store read port is registered,
//   so the byte goes to the read register when the get is accepted and on
//   into the output register in S_READ; no item is taken during S_READ.
// Reset:
//   rst_n clears the ring to empty and slot_bytes to 1024. The frame store
//   and the length table need no clearing: only committed entries are read.
// Stall:
//   While a result waits on out_ready, puts are still accepted; a get waits
//   until the output register is free or being emptied in that cycle.
module drop_oldest_frame_fifo_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [dofifo_pkg::BYTE_W-1:0]   byte_in,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dofifo_pkg::BYTE_W-1:0]   byte_out,
    output logic                            status,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dofifo_pkg::SLOT_W-1:0]   slot_bytes
);
    import dofifo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // config register is a plain write, never back-pressured
    assign cfg_ready = 1'b1;

    dofifo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    dofifo_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .byte_in   (byte_in),
        .frame_end (frame_end),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (slot_bytes),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .status    (status),
        .last      (last)
    );

endmodule

// File: sv/dofifo_chk.sv
// Port-level checker for the drop-oldest frame FIFO, bound to the top level.
// Depends on dofifo_pkg and drop_oldest_frame_fifo_unit.
module dofifo_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            operation,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [dofifo_pkg::BYTE_W-1:0]   byte_out,
    input logic                            status,
    input logic                            last
);
    import dofifo_pkg::*;

    logic get_acc;

    assign get_acc = in_valid && in_ready && (operation == OP_GET);

    // silence bytes are zero
    a_sil_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> byte_out == '0)
        else $error("underrun item carries nonzero byte");

    // a new result only follows an accepted get, through the read register and the output register
    a_rise_after_get: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(get_acc, 2))
        else $error("result without a get");

    // a get occupies the block in its read state; the output register is empty then
    a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
        get_acc |=> !in_ready && !out_valid)
        else $error("item accepted during get read cycle");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out)
            && $stable(status) && $stable(last))
        else $error("stalled result changed");

endmodule

bind drop_oldest_frame_fifo_unit dofifo_chk u_dofifo_chk (.*);

// File: tb/drop_oldest_frame_fifo_unit_test.sv
// Self-checking testbench for drop_oldest_frame_fifo_unit: a directed script, then random frame
// traffic over several slot sizes, every result checked against a cycle-free ring predictor.
// Depends on dofifo_pkg and the drop_oldest_frame_fifo_unit RTL.
module drop_oldest_frame_fifo_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dofifo_pkg::*;

    // status field codes
    localparam logic STATUS_FRAME    = 1'b0;
    localparam logic STATUS_UNDERRUN = 1'b1;

    // a get result passes the read and output registers; settling also covers a trailing put
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int NUM_PHASES    = 9;

    typedef struct packed
    {
        logic [BYTE_W-1:0] data;
        logic              underrun;
        logic              final_byte;
    } out_byte_t;

    typedef struct packed
    {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              fe;
        logic              typed;   // want holds a hand-written result
        out_byte_t         want;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    op_t               operation = OP_PUT;
    logic [BYTE_W-1:0] byte_in = '0;
    logic              frame_end = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] byte_out;
    logic              status;
    logic              last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SLOT_W-1:0] slot_bytes = '0;

    drop_oldest_frame_fifo_unit uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .byte_in    (byte_in),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_out   (byte_out),
        .status     (status),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .slot_bytes (slot_bytes)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Ring predictor: own copy of the frame store and pointers.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] ring_bytes [RING_DEPTH][SLOT_BYTES_MAX];
    int unsigned       frame_len [RING_DEPTH];
    int unsigned       head_slot = 0;
    int unsigned       tail_slot = 0;
    int unsigned       frames_held = 0;
    int unsigned       put_offset = 0;   // bytes stored in the open frame
    int unsigned       get_offset = 0;   // next byte of the head or silent frame
    bit                silent_run = 0;
    logic [SLOT_W-1:0] slot_cfg = SLOT_W'(SLOT_BYTES_MAX);

    out_byte_t bytes_due [$];
    out_byte_t oldest_due;

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned underrun_bytes = 0;
    int unsigned oldest_dropped = 0;
    int unsigned cfg_writes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned phase_slot [NUM_PHASES] = '{1, 0, 3, 7, 1024, 2047, 16, 5, 2};
    int unsigned phase_quota [NUM_PHASES] = '{150, 150, 200, 200, 150, 120, 250, 200, 100};

    // zero acts as one, anything past the slot storage is clamped to it
    function automatic int unsigned usable_slot(input logic [SLOT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SLOT_BYTES_MAX)
            return SLOT_BYTES_MAX;
        return 32'(v);
    endfunction

    task automatic advance_frame_ring(input op_t op, input logic [BYTE_W-1:0] data,
                                      input logic fe, output bit produced,
                                      output out_byte_t r);
        int unsigned span;
        bit          at_end;
        produced = 0;
        r = '0;
        span = usable_slot(slot_cfg);
        if (op == OP_PUT)
        begin
            // first byte of a frame into a full ring pushes out the oldest frame
            if (put_offset == 0 && frames_held >= RING_DEPTH)
            begin
                head_slot = (head_slot + 1) % RING_DEPTH;
                frames_held = RING_DEPTH - 1;
                if (!silent_run)
                    get_offset = 0;
                oldest_dropped++;
            end
            if (put_offset < span)
            begin
                ring_bytes[tail_slot][put_offset] = data;
                put_offset++;
            end
            if (fe)
            begin
                frame_len[tail_slot] = (put_offset < span) ? put_offset : span;
                tail_slot = (tail_slot + 1) % RING_DEPTH;
                if (frames_held < RING_DEPTH)
                    frames_held++;
                put_offset = 0;
            end
        end
        else
        begin
            produced = 1;
            if (!silent_run && frames_held == 0)
            begin
                silent_run = 1;
                get_offset = 0;
            end
            at_end = (get_offset + 1) >= span;
            r.final_byte = at_end;
            if (silent_run)
            begin
                r.data = '0;
                r.underrun = STATUS_UNDERRUN;
                if (at_end)
                begin
                    silent_run = 0;
                    get_offset = 0;
                end
                else
                    get_offset++;
            end
            else
            begin
                r.underrun = STATUS_FRAME;
                if (get_offset < frame_len[head_slot] && get_offset < SLOT_BYTES_MAX)
                    r.data = ring_bytes[head_slot][get_offset];
                if (at_end)
                begin
                    head_slot = (head_slot + 1) % RING_DEPTH;
                    frames_held--;
                    get_offset = 0;
                end
                else
                    get_offset++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. in_valid is only lowered when a gap follows, so a
    // back-to-back item never sees two assignments in one time step.
    // ------------------------------------------------------------------
    task automatic offer_item(input op_t op, input logic [BYTE_W-1:0] data, input logic fe,
                              input logic typed, input out_byte_t typed_want);
        bit        produced;
        out_byte_t want;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        operation <= op;
        byte_in <= data;
        frame_end <= fe;
        do
            @(posedge clk);
        while (!in_ready);
        advance_frame_ring(op, data, fe, produced, want);
        if (produced)
        begin
            bytes_due.push_back(typed ? typed_want : want);
            if (want.underrun == STATUS_UNDERRUN)
                underrun_bytes++;
        end
        items_sent++;
    endtask

    // a get carries random filler in the put-only fields
    task automatic offer_get();
        offer_item(OP_GET, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
    endtask

    task automatic offer_frame(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            offer_item(OP_PUT, BYTE_W'($urandom_range(255)), k == len - 1, 1'b0, '0);
    endtask

    // mostly short frames; full and overlong ones only where the slot is small
    function automatic int unsigned frame_size(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(9);
        if (span <= 64 && pick == 0)
            return span + $urandom_range(2);
        if (span <= 64 && pick == 1 && span > 1)
            return span - 1;
        if (span > 64 && pick == 0)
            return 60;
        return $urandom_range(1, (span < 8) ? span : 8);
    endfunction

    task automatic stream_random(input int unsigned quota);
        int unsigned stop_at;
        int unsigned span;
        int unsigned pick;
        int unsigned n;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            span = usable_slot(slot_cfg);
            pick = $urandom_range(9);
            if (pick <= 3)
                offer_frame(frame_size(span));
            else if (pick <= 6)
            begin
                // a short burst of reads, often ending inside a frame
                n = $urandom_range(1, (span + 2 < 24) ? span + 2 : 24);
                repeat (n) offer_get();
            end
            else if (pick == 7)
            begin
                // flood of tiny frames to overfill the ring
                n = $urandom_range(14, 20);
                repeat (n) offer_frame($urandom_range(1, (span < 3) ? span : 3));
            end
            else if (pick == 8)
                // stray item, may leave a frame open across a phase change
                offer_item(op_t'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                           1'($urandom_range(1)), 1'b0, '0);
            else
            begin
                // drain one to four whole slots, or 64 bytes where the slot is larger
                n = (span > 64) ? 64 : span * $urandom_range(1, 4);
                repeat (n) offer_get();
            end
        end
        in_valid <= 1'b0;
    endtask

    // slot size only changes with nothing in flight
    task automatic write_slot_bytes(input logic [SLOT_W-1:0] v);
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        slot_bytes <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slot_cfg = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result checker.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bytes_due.size() == 0)
            begin
                $error("result with nothing expected: byte_out=%0h status=%0b last=%0b",
                       byte_out, status, last);
                mismatches++;
            end
            else
            begin
                oldest_due = bytes_due.pop_front();
                bytes_checked++;
                if (byte_out !== oldest_due.data)
                begin
                    $error("byte_out: expected %0h, got %0h", oldest_due.data, byte_out);
                    mismatches++;
                end
                if (status !== oldest_due.underrun)
                begin
                    $error("status: expected %0b, got %0b", oldest_due.underrun, status);
                    mismatches++;
                end
                if (last !== oldest_due.final_byte)
                begin
                    $error("last: expected %0b, got %0b", oldest_due.final_byte, last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed script, run with slot_bytes = 2.
    // ------------------------------------------------------------------
    function automatic script_row_t script_row(input op_t op, input logic [BYTE_W-1:0] data,
                                               input logic fe, input logic typed,
                                               input logic [BYTE_W-1:0] want_data,
                                               input logic want_status,
                                               input logic want_last);
        script_row_t r;
        r.op = op;
        r.data = data;
        r.fe = fe;
        r.typed = typed;
        r.want.data = want_data;
        r.want.underrun = want_status;
        r.want.final_byte = want_last;
        return r;
    endfunction

    script_row_t opening_script [25];

    initial
    begin
        opening_script = '{
            // empty ring: a get opens a silent frame
            script_row(OP_GET, 8'h00, 1'b0, 1'b1, 8'h00, STATUS_UNDERRUN, 1'b0),
            // a frame arrives, but the silent frame still runs to its end
            script_row(OP_PUT, 8'hFF, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_GET, 8'hFF, 1'b1, 1'b1, 8'h00, STATUS_UNDERRUN, 1'b1),
            // overlong frame: third byte dropped, frame_end still commits
            script_row(OP_PUT, 8'h01, 1'b0, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h02, 1'b0, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h03, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            // fourteen one-byte frames fill the ring to sixteen
            script_row(OP_PUT, 8'h00, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h80, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h7F, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h10, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h20, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h40, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h08, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h04, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'hAA, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h55, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'hC3, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h3C, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'hFE, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'h01, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            // start reading the head frame
            script_row(OP_GET, 8'h00, 1'b0, 1'b1, 8'hFF, STATUS_FRAME, 1'b0),
            // new frame into a full ring drops the head mid-read
            script_row(OP_PUT, 8'h55, 1'b0, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            // reading restarts on the new head
            script_row(OP_GET, 8'h00, 1'b0, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_GET, 8'hFF, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0),
            script_row(OP_PUT, 8'hAA, 1'b1, 1'b0, 8'h00, STATUS_FRAME, 1'b0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_slot_bytes(SLOT_W'(2));
        foreach (opening_script[i])
            offer_item(opening_script[i].op, opening_script[i].data, opening_script[i].fe,
                       opening_script[i].typed, opening_script[i].want);
        in_valid <= 1'b0;

        // Random phases. Ring contents, open frames and partial reads carry
        // over, so a new slot size also lands in the middle of frames.
        // Idling cycles: none, sender idle, receiver stalling, both.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_slot_bytes(SLOT_W'(phase_slot[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            stream_random(phase_quota[p]);
        end

        for (int k = 0; k < DRAIN_LIMIT && bytes_due.size() != 0; k++)
            @(posedge clk);
        if (bytes_due.size() != 0)
        begin
            $error("%0d expected results never arrived", bytes_due.size());
            mismatches++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("covered %0d items, %0d results checked (%0d underrun), %0d slot size writes",
                 items_sent, bytes_checked, underrun_bytes, cfg_writes);
        $display("oldest frame dropped %0d times on a full ring, %0d mismatches",
                 oldest_dropped, mismatches);
        if (mismatches == 0)
            $display("drop_oldest_frame_fifo_unit_test: done, clean");
        else
            $display("drop_oldest_frame_fifo_unit_test: done, errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("drop_oldest_frame_fifo_unit_test: done, errors");
        $finish;
    end

endmodule
